[hw/rtl/lbnr_pkg.sv]
package lbnr_pkg;

    localparam int OUT_BITS = 16;
    localparam int NBITS_W  = 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic                rng_valid;
        logic [OUT_BITS-1:0] total;
        logic                last;
        logic                overflow;
    } t_range;

endpackage

[hw/rtl/loss_bitmap_nack_run_encoder_core.sv]
// Loss-bitmap NACK run encoder. Bitmap words arrive MSB first (1 = received) and
// are scanned one bit per clock through a shift register; each maximal run of
// zeros, which may span words, comes out as one word (start, length, running
// total). The clamped valid_bits count sets how many bits of a word are scanned;
// a final word then enters S_FIN to close the open run, mark the last word, or
// to give the empty marker when it produced no range. A new input word is taken
// only when the previous one is fully scanned. Scanning stalls while the output
// register holds a word not yet taken and another range is ready. Positions past
// 2^SEQ_BITS-1 saturate and set the overflow flag until the bitmap ends.
module loss_bitmap_nack_run_encoder_core #(
    parameter int WORD_BITS = 32,
    parameter int SEQ_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [WORD_BITS-1:0]          i_bitmap_word,
    input  logic [lbnr_pkg::NBITS_W-1:0]  i_valid_bits,
    input  logic                          i_final_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lbnr_pkg::OUT_BITS-1:0] o_range_start,
    output logic [lbnr_pkg::OUT_BITS-1:0] o_range_length,
    output logic                          o_range_valid,
    output logic [lbnr_pkg::OUT_BITS-1:0] o_range_total,
    output logic                          o_last_result,
    output logic                          o_position_overflow
);
    import lbnr_pkg::*;

    localparam int LEFT_W = $clog2(WORD_BITS + 1);
    localparam int CMP_W  = NBITS_W + 2;

    t_state                r_state, n_state;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_fin, n_fin;
    logic [SEQ_BITS:0]     r_bit_pos, n_bit_pos;
    logic                  r_run_open, n_run_open;
    logic [SEQ_BITS-1:0]   r_run_begin, n_run_begin;
    logic [SEQ_BITS-1:0]   r_run_count, n_run_count;
    logic [SEQ_BITS-1:0]   r_ranges, n_ranges;
    logic                  r_ovf, n_ovf;
    logic                  r_pend_valid, n_pend_valid;
    t_range                r_pend, n_pend;

    logic                  w_slot_free;
    logic                  w_push;
    t_range                w_push_data;
    t_range                w_out;
    logic                  w_bit;
    logic                  w_sat;
    logic [SEQ_BITS-1:0]   w_pos;
    logic [SEQ_BITS-1:0]   w_ranges_inc;
    logic [SEQ_BITS-1:0]   w_count_inc;

    assign o_ready      = (r_state == S_IDLE);
    assign w_bit        = r_word[WORD_BITS-1];
    assign w_sat        = r_bit_pos[SEQ_BITS];
    assign w_pos        = w_sat ? '1 : r_bit_pos[SEQ_BITS-1:0];
    assign w_ranges_inc = (r_ranges == '1) ? r_ranges : r_ranges + 1'b1;
    assign w_count_inc  = (r_run_count == '1) ? r_run_count : r_run_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_left       <= '0;
            r_fin        <= 1'b0;
            r_bit_pos    <= '0;
            r_run_open   <= 1'b0;
            r_run_begin  <= '0;
            r_run_count  <= '0;
            r_ranges     <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_left       <= n_left;
            r_fin        <= n_fin;
            r_bit_pos    <= n_bit_pos;
            r_run_open   <= n_run_open;
            r_run_begin  <= n_run_begin;
            r_run_count  <= n_run_count;
            r_ranges     <= n_ranges;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_pend <= n_pend;
    end

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_left       = r_left;
        n_fin        = r_fin;
        n_bit_pos    = r_bit_pos;
        n_run_open   = r_run_open;
        n_run_begin  = r_run_begin;
        n_run_count  = r_run_count;
        n_ranges     = r_ranges;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        w_push       = 1'b0;
        w_push_data  = r_pend;
        w_push_data.last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word = i_bitmap_word;
                    n_fin  = i_final_word;
                    if (CMP_W'(i_valid_bits) > CMP_W'(WORD_BITS)) begin
                        n_left = LEFT_W'(WORD_BITS);
                    end else begin
                        n_left = LEFT_W'(i_valid_bits);
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_left == '0) begin
                    if (r_fin) begin
                        n_state = S_FIN;
                    end else if (!r_pend_valid) begin
                        n_state = S_IDLE;
                    end else if (w_slot_free) begin
                        w_push       = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (!(w_bit && r_run_open && r_pend_valid && !w_slot_free)) begin
                    n_ovf = r_ovf | w_sat;
                    if (!w_bit) begin
                        if (!r_run_open) begin
                            n_run_open  = 1'b1;
                            n_run_begin = w_pos;
                            n_run_count = SEQ_BITS'(1);
                        end else begin
                            n_run_count = w_count_inc;
                        end
                    end else if (r_run_open) begin
                        n_ranges         = w_ranges_inc;
                        n_pend.start     = OUT_BITS'(r_run_begin);
                        n_pend.length    = OUT_BITS'(r_run_count);
                        n_pend.rng_valid = 1'b1;
                        n_pend.total     = OUT_BITS'(w_ranges_inc);
                        n_pend.last      = 1'b0;
                        n_pend.overflow  = r_ovf | w_sat;
                        n_pend_valid     = 1'b1;
                        w_push           = r_pend_valid;
                        n_run_open       = 1'b0;
                        n_run_begin      = '0;
                        n_run_count      = '0;
                    end
                    if (!w_sat) begin
                        n_bit_pos = r_bit_pos + 1'b1;
                    end
                    n_word = {r_word[WORD_BITS-2:0], 1'b0};
                    n_left = r_left - 1'b1;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    w_push = 1'b1;
                    if (r_pend_valid) begin
                        w_push_data.last = !r_run_open;
                        n_pend_valid     = 1'b0;
                    end else if (r_run_open) begin
                        w_push_data.start     = OUT_BITS'(r_run_begin);
                        w_push_data.length    = OUT_BITS'(r_run_count);
                        w_push_data.rng_valid = 1'b1;
                        w_push_data.total     = OUT_BITS'(w_ranges_inc);
                        w_push_data.last      = 1'b1;
                        w_push_data.overflow  = r_ovf;
                    end else begin
                        w_push_data.start     = '0;
                        w_push_data.length    = '0;
                        w_push_data.rng_valid = 1'b0;
                        w_push_data.total     = OUT_BITS'(r_ranges);
                        w_push_data.last      = 1'b1;
                        w_push_data.overflow  = r_ovf;
                    end
                    if (!r_pend_valid || !r_run_open) begin
                        n_bit_pos   = '0;
                        n_run_open  = 1'b0;
                        n_run_begin = '0;
                        n_run_count = '0;
                        n_ranges    = '0;
                        n_ovf       = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    lbnr_out_slot u_out_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_data),
        .o_free  (w_slot_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (w_out)
    );

    assign o_range_start       = w_out.start;
    assign o_range_length      = w_out.length;
    assign o_range_valid       = w_out.rng_valid;
    assign o_range_total       = w_out.total;
    assign o_last_result       = w_out.last;
    assign o_position_overflow = w_out.overflow;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending range left behind at idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_FIN) && r_state == S_IDLE) |->
            (r_bit_pos == '0 && !r_run_open && r_ranges == '0 && !r_ovf))
        else $error("bitmap state not cleared after final word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> (r_run_count != '0))
        else $error("open run with zero length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_data.last) |=> (r_state == S_IDLE))
        else $error("last word sent before bitmap closed");

endmodule

[hw/rtl/lbnr_out_slot.sv]
module lbnr_out_slot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbnr_pkg::t_range i_word,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output lbnr_pkg::t_range o_word
);
    import lbnr_pkg::*;

    logic   r_valid;
    t_range r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free)
        else $error("push into occupied output slot");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && !i_push) |=> (o_valid && $stable(o_word)))
        else $error("stalled output word changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> (o_valid && o_word == $past(i_word)))
        else $error("pushed word not captured");

endmodule

[tb/loss_bitmap_nack_run_encoder_core_test.sv]
`timescale 1ns / 1ps

module loss_bitmap_nack_run_encoder_core_test;
    import lbnr_pkg::*;

    localparam int WORD_W       = 32;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_ITEMS   = 180;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [NBITS_W-1:0] nbits;
        logic               fin;
        bit                 typed;
        t_range             exp;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [WORD_W-1:0]   i_bitmap_word = '0;
    logic [NBITS_W-1:0]  i_valid_bits = '0;
    logic                i_final_word = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [OUT_BITS-1:0] o_range_start;
    logic [OUT_BITS-1:0] o_range_length;
    logic                o_range_valid;
    logic [OUT_BITS-1:0] o_range_total;
    logic                o_last_result;
    logic                o_position_overflow;

    loss_bitmap_nack_run_encoder_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_bitmap_word       (i_bitmap_word),
        .i_valid_bits        (i_valid_bits),
        .i_final_word        (i_final_word),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_range_start       (o_range_start),
        .o_range_length      (o_range_length),
        .o_range_valid       (o_range_valid),
        .o_range_total       (o_range_total),
        .o_last_result       (o_last_result),
        .o_position_overflow (o_position_overflow)
    );

    t_range pending_ranges[$];
    t_row   stim_rows[$];
    t_range exp_r;

    logic [16:0]         scan_pos;
    bit                  run_open;
    logic [OUT_BITS-1:0] run_begin;
    logic [OUT_BITS-1:0] run_len;
    logic [OUT_BITS-1:0] range_cnt;
    bit                  ovf_seen;

    int  mismatch_cnt = 0;
    int  idle_cycles = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    bit  valid_up = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_pct = 0;
    int  rx_cycle = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_range mk_range(logic [15:0] start, logic [15:0] len, logic vld,
                                        logic [15:0] total, logic last, logic ovf);
        t_range r;
        r.start     = start;
        r.length    = len;
        r.rng_valid = vld;
        r.total     = total;
        r.last      = last;
        r.overflow  = ovf;
        return r;
    endfunction

    function automatic t_row mk_row(logic [31:0] word, logic [5:0] nbits, logic fin,
                                    bit typed, t_range exp);
        t_row r;
        r.word  = word;
        r.nbits = nbits;
        r.fin   = fin;
        r.typed = typed;
        r.exp   = exp;
        return r;
    endfunction

    task automatic clear_scan_state();
        scan_pos  = '0;
        run_open  = 1'b0;
        run_begin = '0;
        run_len   = '0;
        range_cnt = '0;
        ovf_seen  = 1'b0;
    endtask

    task automatic close_loss_run(inout int k);
        if (!run_open) return;
        if (range_cnt != 16'hFFFF) range_cnt++;
        pending_ranges.push_back(mk_range(run_begin, run_len, 1'b1, range_cnt, 1'b0, ovf_seen));
        k++;
        run_open  = 1'b0;
        run_len   = '0;
        run_begin = '0;
    endtask

    task automatic scan_bitmap_word(logic [31:0] word, logic [5:0] nbits, logic fin);
        int          n;
        int          k;
        logic [16:0] p;
        t_range      tail;
        n = (nbits > WORD_W) ? WORD_W : nbits;
        k = 0;
        for (int j = 0; j < n; j++) begin
            p = scan_pos;
            if (p > 17'hFFFF) begin
                ovf_seen = 1'b1;
                p = 17'hFFFF;
            end
            if (!word[WORD_W-1-j]) begin
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_begin = p[15:0];
                    run_len   = '0;
                end
                if (run_len != 16'hFFFF) run_len++;
            end else begin
                close_loss_run(k);
            end
            if (scan_pos < 17'h10000) scan_pos++;
        end
        if (fin) begin
            close_loss_run(k);
            if (k == 0) pending_ranges.push_back(mk_range('0, '0, 1'b0, range_cnt, 1'b0, ovf_seen));
            tail = pending_ranges.pop_back();
            tail.last = 1'b1;
            pending_ranges.push_back(tail);
            clear_scan_state();
        end
    endtask

    task automatic offer_word(logic [31:0] word, logic [5:0] nbits, logic fin, bit predict);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on && $urandom_range(0, 7) != 0) gap = $urandom_range(1, 40);
        end
        if (gap > 0) begin
            if (valid_up) begin
                i_valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        valid_up      = 1'b1;
        i_bitmap_word <= word;
        i_valid_bits  <= nbits;
        i_final_word  <= fin;
        do @(posedge i_clk); while (!o_ready);
        if (predict) scan_bitmap_word(word, nbits, fin);
        burst_left--;
    endtask

    task automatic drain_results();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
        do @(posedge i_clk); while (pending_ranges.size() != 0);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom | $urandom | $urandom;
            2: return $urandom & $urandom & $urandom;
            3: return 32'h0000_0000;
            4: return 32'hFFFF_FFFF;
            default: return 32'hFFFF_FFFF << $urandom_range(0, 31);
        endcase
    endfunction

    // receiver: random stall pattern per window, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_ranges.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: start %0d len %0d vld %0b total %0d last %0b ovf %0b",
                             o_range_start, o_range_length, o_range_valid, o_range_total,
                             o_last_result, o_position_overflow);
            end else begin
                exp_r = pending_ranges.pop_front();
                if (o_range_start !== exp_r.start || o_range_length !== exp_r.length ||
                    o_range_valid !== exp_r.rng_valid || o_range_total !== exp_r.total ||
                    o_last_result !== exp_r.last || o_position_overflow !== exp_r.overflow) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0d/%0d/%0b/%0d/%0b/%0b got %0d/%0d/%0b/%0d/%0b/%0b",
                                 exp_r.start, exp_r.length, exp_r.rng_valid, exp_r.total,
                                 exp_r.last, exp_r.overflow, o_range_start, o_range_length,
                                 o_range_valid, o_range_total, o_last_result,
                                 o_position_overflow);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int   items;
        int   nwords;
        int   i;
        logic [5:0] nb;
        t_range none;
        none = '0;
        clear_scan_state();

        stim_rows.push_back(mk_row(32'hFFFF_FFFF, 6'd32, 1'b1, 1, mk_range(0, 0, 0, 0, 1, 0)));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd32, 1'b1, 1, mk_range(0, 32, 1, 1, 1, 0)));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd0,  1'b1, 1, mk_range(0, 0, 0, 0, 1, 0)));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd63, 1'b1, 1, mk_range(0, 32, 1, 1, 1, 0)));
        stim_rows.push_back(mk_row(32'h7FFF_FFFF, 6'd32, 1'b1, 1, mk_range(0, 1, 1, 1, 1, 0)));
        stim_rows.push_back(mk_row(32'hFFFF_FFFE, 6'd32, 1'b1, 1, mk_range(31, 1, 1, 1, 1, 0)));
        stim_rows.push_back(mk_row(32'hFFFF_FFFE, 6'd31, 1'b1, 1, mk_range(0, 0, 0, 0, 1, 0)));
        stim_rows.push_back(mk_row(32'h8000_0000, 6'd1,  1'b1, 1, mk_range(0, 0, 0, 0, 1, 0)));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd1,  1'b1, 1, mk_range(0, 1, 1, 1, 1, 0)));
        stim_rows.push_back(mk_row(32'hFFFF_0000, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'h0000_FFFF, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'hAAAA_AAAA, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'h1234_5678, 6'd20, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd0,  1'b0, 0, none));
        stim_rows.push_back(mk_row(32'hFFFF_FFFF, 6'd33, 1'b1, 0, none));
        stim_rows.push_back(mk_row(32'h0F0F_0F0F, 6'd32, 1'b1, 0, none));
        stim_rows.push_back(mk_row(32'h5555_5555, 6'd32, 1'b1, 0, none));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd32, 1'b1, 0, none));
        stim_rows.push_back(mk_row(32'hFFFF_FFF0, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'hFFFF_FFFF, 6'd32, 1'b1, 0, none));
        stim_rows.push_back(mk_row(32'hFFFF_FF00, 6'd32, 1'b0, 0, none));
        stim_rows.push_back(mk_row(32'h0000_0000, 6'd0,  1'b1, 0, none));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].typed) pending_ranges.push_back(stim_rows[r].exp);
            offer_word(stim_rows[r].word, stim_rows[r].nbits, stim_rows[r].fin,
                       !stim_rows[r].typed);
        end
        drain_results();

        items = 0;
        while (items < RAND_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                offer_word($urandom, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1);
                items++;
                if (items == RAND_ITEMS / 2) hold_req = 1'b1;
            end else begin
                nwords = $urandom_range(1, 6);
                for (i = 0; i < nwords; i++) begin
                    nb = ($urandom_range(0, 9) < 7) ? 6'd32 : 6'($urandom_range(0, 63));
                    offer_word(rand_word(), nb, i == nwords - 1, 1);
                    items++;
                    if (items == RAND_ITEMS / 2) hold_req = 1'b1;
                end
            end
        end
        drain_results();

        gaps_on = 1'b1;
        for (i = 0; i < 4; i++) offer_word(rand_word(), 6'd32, i == 3, 1);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_ranges.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
